// ===== rtl/bgr_pkg.sv =====
package bgr_pkg;

  // Default width of the drawing coordinates.
  localparam int unsigned COORD_BITS_DEF = 16;

  // Configuration port.
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X    = 2'd0,
    CFG_START_Y    = 2'd1,
    CFG_SCALE      = 2'd2,
    CFG_TEXT_COLOR = 2'd3
  } cfg_idx_e;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned SCALE_W = 4;
  localparam int unsigned COLOR_W = 24;

  localparam logic [POS_W-1:0]   START_X_RST    = '0;
  localparam logic [POS_W-1:0]   START_Y_RST    = '0;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 4'd1;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 24'hFFFFFF;

  // Byte codes of the two-byte C with cedilla.
  localparam logic [7:0] LEAD_BYTE     = 8'hC3;
  localparam logic [7:0] CEDILLA_UPPER = 8'h87;
  localparam logic [7:0] CEDILLA_LOWER = 8'hA7;

  // A glyph advances the cursor by this many dot cells.
  localparam logic [2:0] ADVANCE_CELLS = 3'd6;

  // Glyph geometry.
  localparam int unsigned GLYPH_ROWS = 7;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned ROW_W      = 3;
  localparam int unsigned COL_W      = 3;
  // Row counter value that marks the advance beat after the last dot row.
  localparam logic [ROW_W-1:0] ROW_ADVANCE = ROW_W'(GLYPH_ROWS);
  localparam logic [COL_W-1:0] COL_LAST    = COL_W'(GLYPH_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(GLYPH_ROWS - 1);

  // Glyph numbers: the font entries, and the cedilla in the spare slot.
  localparam int unsigned GLYPH_W       = 5;
  localparam int unsigned GLYPH_COUNT   = 32;
  localparam logic [GLYPH_W-1:0] GLYPH_BLANK   = 5'd0;
  localparam logic [GLYPH_W-1:0] GLYPH_CEDILLA = 5'd31;

  // Depth of the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Result kinds.
  typedef enum logic {
    KIND_RECT    = 1'b0,
    KIND_ADVANCE = 1'b1
  } item_kind_e;

  // One unit of work for the back end.
  typedef struct packed {
    logic               load;   // cursor takes start_x before anything else
    logic               draw;   // a glyph is drawn
    logic [GLYPH_W-1:0] glyph;
    logic               last;   // the advance closes the input beat's results
  } job_t;

  // Rows top first; bit 4 of a row is the left column.
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

  localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},  // space
    '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},  // -
    '{5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00},  // :
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},  // 0
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},  // 1
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},  // 2
    '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},  // 3
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},  // 4
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},  // 5
    '{5'h07, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},  // 6
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},  // 7
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},  // 8
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C},  // 9
    '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},  // A
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},  // C
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},  // E
    '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},  // G
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},  // H
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},  // I
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},  // L
    '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},  // M
    '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},  // N
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},  // O
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},  // P
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h12, 5'h11, 5'h11},  // R
    '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},  // S
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},  // T
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},  // U
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},  // V
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},  // Y
    '{5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E},  // [
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h06}   // C with cedilla
  };

  // Maps a text byte to its glyph number; anything without a glyph is blank.
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] code);
    logic [GLYPH_W-1:0] idx;
    unique case (code)
      8'h2D:   idx = 5'd1;   // -
      8'h3A:   idx = 5'd2;   // :
      8'h30:   idx = 5'd3;
      8'h31:   idx = 5'd4;
      8'h32:   idx = 5'd5;
      8'h33:   idx = 5'd6;
      8'h34:   idx = 5'd7;
      8'h35:   idx = 5'd8;
      8'h36:   idx = 5'd9;
      8'h37:   idx = 5'd10;
      8'h38:   idx = 5'd11;
      8'h39:   idx = 5'd12;
      8'h41:   idx = 5'd13;  // A
      8'h43:   idx = 5'd14;  // C
      8'h45:   idx = 5'd15;  // E
      8'h47:   idx = 5'd16;  // G
      8'h48:   idx = 5'd17;  // H
      8'h49:   idx = 5'd18;  // I
      8'h4C:   idx = 5'd19;  // L
      8'h4D:   idx = 5'd20;  // M
      8'h4E:   idx = 5'd21;  // N
      8'h4F:   idx = 5'd22;  // O
      8'h50:   idx = 5'd23;  // P
      8'h52:   idx = 5'd24;  // R
      8'h53:   idx = 5'd25;  // S
      8'h54:   idx = 5'd26;  // T
      8'h55:   idx = 5'd27;  // U
      8'h56:   idx = 5'd28;  // V
      8'h59:   idx = 5'd29;  // Y
      8'h5B:   idx = 5'd30;  // [
      default: idx = GLYPH_BLANK;
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/bgr_if.sv =====
// Text byte channel.
interface bgr_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       string_start;
  logic       end_of_text;

  modport source (output valid, text_byte, string_start, end_of_text, input ready);
  modport sink   (input valid, text_byte, string_start, end_of_text, output ready);
endinterface

// Drawing item channel.
interface bgr_rect_if #(
  parameter int unsigned COORD_BITS = bgr_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          item_kind;
  logic [COORD_BITS-1:0]         rect_x;
  logic [COORD_BITS-1:0]         rect_y;
  logic [bgr_pkg::SCALE_W-1:0]   rect_size;
  logic [bgr_pkg::COLOR_W-1:0]   rect_color;
  logic [COORD_BITS-1:0]         pen_x;
  logic                          last;

  modport source (output valid, item_kind, rect_x, rect_y, rect_size, rect_color,
                  pen_x, last, input ready);
  modport sink   (input valid, item_kind, rect_x, rect_y, rect_size, rect_color,
                  pen_x, last, output ready);
endinterface

// ===== rtl/bgr_front.sv =====
module bgr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  bgr_text_if.sink        text_i,
  output bgr_pkg::job_t   push_data_o,
  output logic            push_valid_o,
  input  logic            full_i
);

  logic          pend_q, pend_d;
  logic          hold_valid_q, hold_valid_d;
  bgr_pkg::job_t hold_q, hold_d;
  bgr_pkg::job_t j0, j1;
  logic          j0_v, j1_v;
  logic          accept, pend_eff, is_ced, is_lead;

  // A second job waiting in the hold register blocks new beats until it has
  // entered the queue.
  assign text_i.ready = !hold_valid_q && !full_i;
  assign accept       = text_i.valid && text_i.ready;

  assign pend_eff = text_i.string_start ? 1'b0 : pend_q;
  assign is_lead  = (text_i.text_byte == bgr_pkg::LEAD_BYTE);
  assign is_ced   = (text_i.text_byte == bgr_pkg::CEDILLA_UPPER) ||
                    (text_i.text_byte == bgr_pkg::CEDILLA_LOWER);

  always_comb begin
    j0     = '0;
    j1     = '0;
    j0_v   = 1'b0;
    j1_v   = 1'b0;
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b0;
      if (text_i.end_of_text) begin
        if (pend_eff) begin
          j0 = '{load: text_i.string_start, draw: 1'b1, glyph: bgr_pkg::GLYPH_BLANK,
                 last: 1'b1};
          j0_v = 1'b1;
        end else if (text_i.string_start) begin
          j0 = '{load: 1'b1, draw: 1'b0, glyph: bgr_pkg::GLYPH_BLANK, last: 1'b1};
          j0_v = 1'b1;
        end
      end else if (pend_eff && is_ced) begin
        j0 = '{load: 1'b0, draw: 1'b1, glyph: bgr_pkg::GLYPH_CEDILLA, last: 1'b1};
        j0_v = 1'b1;
      end else if (pend_eff) begin
        // The held lead is drawn blank, then the new byte is handled.
        j0 = '{load: 1'b0, draw: 1'b1, glyph: bgr_pkg::GLYPH_BLANK, last: is_lead};
        j0_v = 1'b1;
        if (is_lead) begin
          pend_d = 1'b1;
        end else begin
          j1 = '{load: 1'b0, draw: 1'b1, glyph: bgr_pkg::glyph_of(text_i.text_byte),
                 last: 1'b1};
          j1_v = 1'b1;
        end
      end else if (is_lead) begin
        pend_d = 1'b1;
        if (text_i.string_start) begin
          j0 = '{load: 1'b1, draw: 1'b0, glyph: bgr_pkg::GLYPH_BLANK, last: 1'b1};
          j0_v = 1'b1;
        end
      end else begin
        j0 = '{load: text_i.string_start, draw: 1'b1,
               glyph: bgr_pkg::glyph_of(text_i.text_byte), last: 1'b1};
        j0_v = 1'b1;
      end
    end
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    if (hold_valid_q && !full_i) begin
      hold_valid_d = 1'b0;
    end
    if (j1_v) begin
      hold_valid_d = 1'b1;
      hold_d       = j1;
    end
  end

  assign push_valid_o = hold_valid_q || j0_v;
  assign push_data_o  = hold_valid_q ? hold_q : j0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      pend_q       <= pend_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule

// ===== rtl/bgr_fifo.sv =====
module bgr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bgr_pkg::job_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  output bgr_pkg::job_t pop_data_o,
  input  logic          pop_i
);

  bgr_pkg::job_t                     mem_q [bgr_pkg::QUEUE_DEPTH];
  logic [bgr_pkg::QUEUE_PTR_W-1:0]   wr_q, rd_q;
  logic [bgr_pkg::QUEUE_CNT_W-1:0]   cnt_q;
  logic                              do_push, do_pop;

  assign full_o     = (cnt_q == bgr_pkg::QUEUE_CNT_W'(bgr_pkg::QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  function automatic logic [bgr_pkg::QUEUE_PTR_W-1:0] ptr_next(
    input logic [bgr_pkg::QUEUE_PTR_W-1:0] p
  );
    logic [bgr_pkg::QUEUE_PTR_W-1:0] n;
    if (p == bgr_pkg::QUEUE_PTR_W'(bgr_pkg::QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= ptr_next(wr_q);
      end
      if (do_pop) begin
        rd_q <= ptr_next(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/bgr_back.sv =====
module bgr_back #(
  parameter int unsigned COORD_BITS = bgr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bgr_pkg::POS_W-1:0]   start_x_i,
  input  logic [bgr_pkg::POS_W-1:0]   start_y_i,
  input  logic [bgr_pkg::SCALE_W-1:0] scale_i,
  input  logic [bgr_pkg::COLOR_W-1:0] color_i,
  input  logic                        job_valid_i,
  input  bgr_pkg::job_t               job_i,
  output logic                        job_pop_o,
  bgr_rect_if.source                  rect_o
);

  localparam int unsigned OFF_W = bgr_pkg::COL_W + bgr_pkg::SCALE_W;

  logic                          busy_q, busy_d;
  logic [bgr_pkg::GLYPH_W-1:0]   glyph_q, glyph_d;
  logic                          last_q, last_d;
  logic [bgr_pkg::ROW_W-1:0]     row_q, row_d;
  logic [bgr_pkg::COL_W-1:0]     col_q, col_d;
  logic [COORD_BITS-1:0]         cursor_q, cursor_d;

  logic                          out_valid_q, out_valid_d;
  logic                          out_kind_q, out_kind_d, out_last_q, out_last_d;
  logic [COORD_BITS-1:0]         out_x_q, out_x_d, out_y_q, out_y_d, out_cur_q, out_cur_d;
  logic [bgr_pkg::SCALE_W-1:0]   out_size_q, out_size_d;
  logic [bgr_pkg::COLOR_W-1:0]   out_color_q, out_color_d;

  logic                          step, at_advance, dot_set;
  logic [OFF_W-1:0]              x_off, y_off, adv_off;
  logic [COORD_BITS-1:0]         cursor_next;
  bgr_pkg::glyph_t               glyph_bits;

  // The output register moves on when it is empty or being taken.
  assign step       = !out_valid_q || rect_o.ready;
  assign at_advance = (row_q == bgr_pkg::ROW_ADVANCE);
  assign glyph_bits = bgr_pkg::GLYPH_ROM[glyph_q];
  assign dot_set    = !at_advance &&
                      glyph_bits[row_q][bgr_pkg::COL_W'(bgr_pkg::GLYPH_COLS - 1) - col_q];

  assign x_off       = col_q * scale_i;
  assign y_off       = row_q * scale_i;
  assign adv_off     = bgr_pkg::ADVANCE_CELLS * scale_i;
  assign cursor_next = cursor_q + COORD_BITS'(adv_off);

  // A new job is taken when idle, or in the cycle in which the advance beat is loaded into the output register.
  assign job_pop_o = job_valid_i && (!busy_q || (at_advance && step));

  always_comb begin
    busy_d      = busy_q;
    glyph_d     = glyph_q;
    last_d      = last_q;
    row_d       = row_q;
    col_d       = col_q;
    cursor_d    = cursor_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_cur_d   = out_cur_q;
    out_size_d  = out_size_q;
    out_color_d = out_color_q;

    if (step) begin
      out_valid_d = 1'b0;
    end

    if (busy_q && step) begin
      if (at_advance) begin
        busy_d      = 1'b0;
        cursor_d    = cursor_next;
        out_valid_d = 1'b1;
        out_kind_d  = bgr_pkg::KIND_ADVANCE;
        out_last_d  = last_q;
        out_x_d     = '0;
        out_y_d     = '0;
        out_size_d  = '0;
        out_color_d = '0;
        out_cur_d   = cursor_next;
      end else begin
        if (dot_set) begin
          out_valid_d = 1'b1;
          out_kind_d  = bgr_pkg::KIND_RECT;
          out_last_d  = 1'b0;
          out_x_d     = cursor_q + COORD_BITS'(x_off);
          out_y_d     = COORD_BITS'(start_y_i) + COORD_BITS'(y_off);
          out_size_d  = scale_i;
          out_color_d = color_i;
          out_cur_d   = '0;
        end
        if (col_q == bgr_pkg::COL_LAST) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end

    if (job_pop_o) begin
      busy_d  = job_i.draw;
      glyph_d = job_i.glyph;
      last_d  = job_i.last;
      row_d   = '0;
      col_d   = '0;
      if (job_i.load) begin
        cursor_d = COORD_BITS'(start_x_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q     <= glyph_d;
    last_q      <= last_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_cur_q   <= out_cur_d;
    out_size_q  <= out_size_d;
    out_color_q <= out_color_d;
  end

  assign rect_o.valid      = out_valid_q;
  assign rect_o.item_kind  = out_kind_q;
  assign rect_o.rect_x     = out_x_q;
  assign rect_o.rect_y     = out_y_q;
  assign rect_o.rect_size  = out_size_q;
  assign rect_o.rect_color = out_color_q;
  assign rect_o.pen_x      = out_cur_q;
  assign rect_o.last       = out_last_q;

endmodule

// ===== rtl/bitmap_text_glyph_rasterizer.sv =====
// Draws text as 5x7 dot glyphs. Each beat on text_i carries one UTF-8 byte;
// a known character is looked up in the built-in font, any other byte draws
// the blank glyph, and the pair 0xC3 then 0x87 or 0xA7 draws a C with
// cedilla (a lone 0xC3 is held until the next byte shows what it is). For
// every set dot the block sends a square of side scale on rect_o, scanning
// rows top to bottom and columns left to right, then one advance beat that
// carries the new cursor position; the cursor moves by six times scale and
// wraps at COORD_BITS bits. The last flag marks the final beat caused by an
// input beat. The drawing engine steps through every dot position, set or
// not, and then the advance, and it stalls while a beat waits on rect_o.
// That engine sets the throughput. A two-entry job queue lets the byte
// decoder take further bytes while a glyph is still being drawn.
// Configuration registers are written through cfg_we_i and must only change
// while no drawing is in progress.
module bitmap_text_glyph_rasterizer #(
  parameter int unsigned COORD_BITS = bgr_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bgr_text_if.sink                        text_i,
  bgr_rect_if.source                      rect_o,
  input  logic                            cfg_we_i,
  input  logic [bgr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bgr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // Configuration registers.
  logic [bgr_pkg::POS_W-1:0]   start_x_q, start_y_q;
  logic [bgr_pkg::SCALE_W-1:0] scale_q;
  logic [bgr_pkg::COLOR_W-1:0] color_q;

  // Job queue between the byte decoder and the drawing engine.
  bgr_pkg::job_t push_data, pop_data;
  logic          push_valid, full, pop_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= bgr_pkg::START_X_RST;
      start_y_q <= bgr_pkg::START_Y_RST;
      scale_q   <= bgr_pkg::SCALE_RST;
      color_q   <= bgr_pkg::TEXT_COLOR_RST;
    end else if (cfg_we_i) begin
      unique case (bgr_pkg::cfg_idx_e'(cfg_idx_i))
        bgr_pkg::CFG_START_X:    start_x_q <= cfg_data_i[bgr_pkg::POS_W-1:0];
        bgr_pkg::CFG_START_Y:    start_y_q <= cfg_data_i[bgr_pkg::POS_W-1:0];
        bgr_pkg::CFG_SCALE:      scale_q   <= cfg_data_i[bgr_pkg::SCALE_W-1:0];
        bgr_pkg::CFG_TEXT_COLOR: color_q   <= cfg_data_i[bgr_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // The decoder turns each byte into at most two glyph jobs and keeps the
  // pending lead byte; string starts travel with the jobs so the cursor is
  // reloaded in order with the drawing.
  bgr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (text_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .full_i       (full)
  );

  bgr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (pop_valid),
    .pop_data_o  (pop_data),
    .pop_i       (pop)
  );

  // The drawing engine owns the cursor and the output register.
  bgr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_x_i   (start_x_q),
    .start_y_i   (start_y_q),
    .scale_i     (scale_q),
    .color_i     (color_q),
    .job_valid_i (pop_valid),
    .job_i       (pop_data),
    .job_pop_o   (pop),
    .rect_o      (rect_o)
  );

endmodule
